/* sv/rse_pkg.sv */
// Package for the row softmax engine: shared types, constants and functions.
`default_nettype none
package rse_pkg;

  localparam int MAX_ROW = 64;
  localparam int IDX_W   = $clog2(MAX_ROW);
  localparam int LEN_W   = 7;
  localparam int SCORE_W = 16;
  localparam int VALUE_W = 17;
  localparam int TOTAL_W = 23;

  localparam logic CFG_MODE = 1'b0;
  localparam logic CFG_LEN  = 1'b1;

  // Taylor terms of exp(-1/256) in Q0.56: term_k = term_(k-1) / (256 k), truncated
  localparam logic [63:0] TAY_0 = 64'd1 << 56;
  localparam logic [63:0] TAY_1 = TAY_0 / 64'd256;
  localparam logic [63:0] TAY_2 = TAY_1 / 64'd512;
  localparam logic [63:0] TAY_3 = TAY_2 / 64'd768;
  localparam logic [63:0] TAY_4 = TAY_3 / 64'd1024;
  localparam logic [63:0] TAY_5 = TAY_4 / 64'd1280;
  localparam logic [63:0] TAY_6 = TAY_5 / 64'd1536;
  localparam logic [63:0] TAY_7 = TAY_6 / 64'd1792;
  localparam logic [63:0] TAY_8 = TAY_7 / 64'd2048;

  // exp(-1/256) in Q0.32, alternating sum rounded
  localparam logic [63:0] EXP_E1 = ((TAY_0 + TAY_2 + TAY_4 + TAY_6 + TAY_8)
                                   - (TAY_1 + TAY_3 + TAY_5 + TAY_7)
                                   + (64'd1 << 23)) >> 24;

  // exp(-2^i/256) in Q0.32, i = 0..11, with the same roundings as the repeated squaring
  function automatic logic [32:0] exp_factor(input int i);
    logic [63:0] f;
    logic [127:0] sq;
    begin
      f = EXP_E1;
      for (int j = 0; j < 12; j++) begin
        if (j < i) begin
          sq = 128'(f) * 128'(f) + (128'd1 << 31);
          f = sq[95:32];
        end
      end
      exp_factor = f[32:0];
    end
  endfunction

  // one factor per bit of the exp argument
  localparam logic [11:0][32:0] EXP_F = {
    exp_factor(11), exp_factor(10), exp_factor(9), exp_factor(8),
    exp_factor(7),  exp_factor(6),  exp_factor(5), exp_factor(4),
    exp_factor(3),  exp_factor(2),  exp_factor(1), exp_factor(0)
  };

  typedef enum logic [3:0] {
    ST_FILL,
    ST_SUM_RD,
    ST_SUM_EXP,
    ST_LN_START,
    ST_LN_WAIT,
    ST_OUT_RD,
    ST_OUT_EXP,
    ST_OUT_CALC,
    ST_OUT_HOLD
  } state_t;

  // shared unit command
  typedef enum logic [1:0] {
    OP_EXP,
    OP_LN,
    OP_DIV
  } op_t;

  typedef struct packed {
    logic        start;
    op_t         op;
  } unit_ctl_t;

endpackage
`default_nettype wire

/* sv/rse_unit.sv */
// Shared multi-cycle arithmetic unit: exp(-n), ln(total) and divide.
`default_nettype none
module rse_unit
  import rse_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire unit_ctl_t          ctl,
  input  wire logic [15:0]        n_in,
  input  wire logic [TOTAL_W-1:0] total_in,
  input  wire logic [16:0]        term_in,
  output logic                    busy,
  output logic [31:0]             result
);

  logic        busy_r, busy_nxt;
  op_t         op_r, op_nxt;
  logic [5:0]  step_r, step_nxt;
  logic [33:0] acc_r, acc_nxt;     // exp accumulator Q1.32 / ln mantissa Q1.31 (33 bits)
  logic [15:0] n_r, n_nxt;
  logic [31:0] l2_r, l2_nxt;
  logic [39:0] rem_r, rem_nxt;
  logic [TOTAL_W-1:0] div_r, div_nxt;
  logic [31:0] res_r, res_nxt;
  logic [67:0] prod;
  logic [33:0] mul_a, mul_b;
  logic [33:0] half_m;
  logic [4:0]  top;
  logic [40:0] rdiff;

  assign busy   = busy_r;
  assign result = res_r;

  always_comb begin
    top = '0;
    for (int b = 0; b < TOTAL_W; b++) begin
      if (total_in[b]) top = 5'(b);
    end
  end

  always_comb begin
    mul_a = acc_r;
    mul_b = (op_r == OP_LN) ? acc_r : 34'(EXP_F[step_r[3:0]]);
    prod  = mul_a * mul_b;
  end

  always_comb begin
    busy_nxt = busy_r;
    op_nxt   = op_r;
    step_nxt = step_r;
    acc_nxt  = acc_r;
    n_nxt    = n_r;
    l2_nxt   = l2_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    res_nxt  = res_r;
    half_m   = '0;
    rdiff    = '0;
    if (!busy_r) begin
      if (ctl.start) begin
        op_nxt   = ctl.op;
        busy_nxt = 1'b1;
        step_nxt = '0;
        case (ctl.op)
          OP_EXP: begin
            acc_nxt = 34'd1 << 32;
            n_nxt   = n_in;
            if (n_in >= 16'd4096) begin
              busy_nxt = 1'b0;
              res_nxt  = '0;
            end
          end
          OP_LN: begin
            acc_nxt = 34'(total_in) << (5'd31 - top);
            l2_nxt  = 32'(32'(top) - 32'd16) << 16;
            if (total_in < 23'd65536) begin
              busy_nxt = 1'b0;
              res_nxt  = '0;
            end
          end
          OP_DIV: begin
            rem_nxt = 40'({term_in, 16'd0}) + 40'(total_in >> 1);
            div_nxt = total_in;
            res_nxt = '0;
            if (total_in == '0) busy_nxt = 1'b0;
          end
          default: busy_nxt = 1'b0;
        endcase
      end
    end else begin
      case (op_r)
        OP_EXP: begin
          if (n_r[step_r[3:0]]) acc_nxt = 34'((prod + (68'd1 << 31)) >> 32);
          step_nxt = step_r + 6'd1;
          if (step_r == 6'd11) begin
            busy_nxt = 1'b0;
            res_nxt  = 32'((acc_nxt + 34'd32768) >> 16);
          end
        end
        OP_LN: begin
          if (step_r < 6'd16) begin
            half_m = 34'(prod >> 31);
            if (half_m[32]) begin
              l2_nxt = l2_r | (32'd1 << (5'd15 - step_r[4:0]));
              half_m = half_m >> 1;
            end
            acc_nxt  = half_m;
            step_nxt = step_r + 6'd1;
          end else begin
            // final scale by ln2 (Q0.32 constant); 32x32 product
            res_nxt  = 32'((64'(l2_r) * 64'hB17217F8 + (64'd1 << 39)) >> 40);
            busy_nxt = 1'b0;
          end
        end
        OP_DIV: begin
          // restoring division, one quotient bit per cycle, 17 quotient bits
          rdiff = {1'b0, rem_r} - (41'(div_r) << (6'd16 - step_r));
          if (!rdiff[40]) begin
            rem_nxt = rdiff[39:0];
            res_nxt = res_r | (32'd1 << (5'd16 - step_r[4:0]));
          end
          step_nxt = step_r + 6'd1;
          if (step_r == 6'd16) busy_nxt = 1'b0;
        end
        default: busy_nxt = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      op_r   <= OP_EXP;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      op_r   <= op_nxt;
      step_r <= step_nxt;
    end
    acc_r <= acc_nxt;
    n_r   <= n_nxt;
    l2_r  <= l2_nxt;
    rem_r <= rem_nxt;
    div_r <= div_nxt;
    res_r <= res_nxt;
  end

endmodule
`default_nettype wire

/* sv/row_softmax_engine.sv */
// Top level of the row softmax engine: row buffer, sequencer and output register.
`default_nettype none
// Scores (signed Q8.8) stream in one per transfer; row_length of them form a
// row (0 acts as 1, above 64 as 64). The row is stored in a 64-entry buffer
// while the maximum is tracked, one score per cycle. After the last score the
// block stops taking input and makes two passes over the buffer with one
// shared arithmetic unit: an exp pass summing exp(x-max) through the 12-step
// exp multiply chain (cut short when the term is zero), then, in log mode, an
// ln, then an output pass giving one result per score (in softmax mode the
// exp is followed by a 17-step bit-serial divide); each result waits while
// the previous one is held by out_stall. Results leave through a held
// output register; row_end marks the last result of a row. mode is sampled
// when a row completes.
module row_softmax_engine
  import rse_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_we,
  input  wire logic                cfg_index,
  input  wire logic [LEN_W-1:0]    cfg_data,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic signed [15:0]  in_score,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic signed [16:0]       out_value,
  output logic                     out_row_end
);

  state_t state_r, state_nxt;
  logic               mode_r, row_mode_r;
  logic [LEN_W-1:0]   len_r;
  logic [LEN_W-1:0]   fill_r, fill_nxt;
  logic [LEN_W-1:0]   idx_r, idx_nxt;
  logic signed [15:0] max_r;
  logic [TOTAL_W-1:0] total_r;
  logic signed [15:0] lse_r;
  logic signed [15:0] rd_r;
  logic signed [15:0] mem [MAX_ROW];
  logic [LEN_W-1:0]   eff_len;
  logic               in_acc, out_acc;
  logic               ov_r;
  logic signed [16:0] ovalue_r, ovalue_nxt;
  logic               oend_r;
  unit_ctl_t          ctl;
  logic               u_busy;
  logic [31:0]        u_res;
  logic [15:0]        n_val;
  logic signed [17:0] lr;
  logic [IDX_W-1:0]   rd_addr;
  logic               started_r;

  always_comb begin
    eff_len = len_r;
    if (len_r == '0) eff_len = 7'd1;
    if (len_r > 7'(MAX_ROW)) eff_len = 7'(MAX_ROW);
  end

  assign in_stall  = (state_r != ST_FILL);
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = ov_r;
  assign out_value = ovalue_r;
  assign out_row_end = oend_r;
  assign out_acc   = ov_r && !out_stall;
  assign n_val     = 16'(max_r - rd_r);
  assign rd_addr   = idx_r[IDX_W-1:0];

  rse_unit u_unit (
    .clk, .rst_n, .ctl, .n_in(n_val), .total_in(total_r), .term_in(u_res[16:0]),
    .busy(u_busy), .result(u_res)
  );

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
      len_r  <= 7'd64;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MODE: mode_r <= cfg_data[0];
        CFG_LEN:  len_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // row buffer: one write port, one registered read
  always_ff @(posedge clk) begin
    if (in_acc) mem[fill_r[IDX_W-1:0]] <= in_score;
    rd_r <= mem[rd_addr];
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_FILL:     if (in_acc && fill_r + 7'd1 >= eff_len) state_nxt = ST_SUM_RD;
      ST_SUM_RD:   state_nxt = ST_SUM_EXP;
      ST_SUM_EXP:  if (!u_busy && !ctl.start) begin
        state_nxt = (idx_r + 7'd1 == fill_r) ?
                    (row_mode_r ? ST_LN_START : ST_OUT_RD) : ST_SUM_RD;
      end
      ST_LN_START: state_nxt = ST_LN_WAIT;
      ST_LN_WAIT:  if (!u_busy) state_nxt = ST_OUT_RD;
      ST_OUT_RD:   if (!ov_r || out_acc) state_nxt = ST_OUT_EXP;
      ST_OUT_EXP:  if (!u_busy && !ctl.start) state_nxt = ST_OUT_CALC;
      ST_OUT_CALC: if (!u_busy && !ctl.start) state_nxt = ST_OUT_HOLD;
      ST_OUT_HOLD: state_nxt = (idx_r + 7'd1 == fill_r) ? ST_FILL : ST_OUT_RD;
      default:     state_nxt = ST_FILL;
    endcase
  end

  // unit control: start pulses on entry of each working state (the output exp and divide only in softmax mode)
  always_comb begin
    ctl.start = 1'b0;
    ctl.op    = OP_EXP;
    case (state_r)
      ST_SUM_EXP:  ctl.start = !started_r;
      ST_LN_START: begin ctl.start = 1'b1; ctl.op = OP_LN; end
      ST_OUT_EXP:  ctl.start = !started_r && !row_mode_r;
      ST_OUT_CALC: begin ctl.start = !started_r && !row_mode_r; ctl.op = OP_DIV; end
      default: ;
    endcase
  end

  always_comb begin
    lr = 18'(17'(rd_r) - 17'(max_r)) - 18'(lse_r);
    ovalue_nxt = ovalue_r;
    if (row_mode_r) begin
      if (lr < -18'sd32768) ovalue_nxt = -17'sd32768;
      else if (lr > 18'sd32767) ovalue_nxt = 17'sd32767;
      else ovalue_nxt = lr[16:0];
    end else begin
      ovalue_nxt = (u_res[16]) ? 17'd65535 : {1'b0, u_res[15:0]};
    end
  end

  always_comb begin
    fill_nxt = fill_r;
    idx_nxt  = idx_r;
    if (in_acc) fill_nxt = fill_r + 7'd1;
    case (state_r)
      ST_SUM_EXP:  if (state_nxt != ST_SUM_EXP)
        idx_nxt = (state_nxt == ST_SUM_RD) ? idx_r + 7'd1 : '0;
      ST_OUT_HOLD: idx_nxt = (state_nxt == ST_FILL) ? '0 : idx_r + 7'd1;
      ST_FILL:     idx_nxt = '0;
      default: ;
    endcase
    if (state_r == ST_OUT_HOLD && state_nxt == ST_FILL) fill_nxt = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_FILL;
      fill_r    <= '0;
      idx_r     <= '0;
      max_r     <= '0;
      total_r   <= '0;
      lse_r     <= '0;
      ov_r      <= 1'b0;
      oend_r    <= 1'b0;
      started_r <= 1'b0;
      row_mode_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      fill_r    <= fill_nxt;
      idx_r     <= idx_nxt;
      started_r <= (state_nxt == state_r) && (ctl.start || started_r);
      if (in_acc && (fill_r == '0 || in_score > max_r)) max_r <= in_score;
      if (state_r == ST_FILL && state_nxt == ST_SUM_RD) begin
        total_r    <= '0;
        row_mode_r <= mode_r;
      end
      if (state_r == ST_SUM_EXP && state_nxt != ST_SUM_EXP)
        total_r <= total_r + u_res[TOTAL_W-1:0];
      if (state_r == ST_LN_WAIT && !u_busy) lse_r <= u_res[15:0];
      if (out_acc) ov_r <= 1'b0;
      if (state_r == ST_OUT_HOLD) begin
        ov_r   <= 1'b1;
        oend_r <= (idx_r + 7'd1 == fill_r);
      end
    end
    if (state_r == ST_OUT_HOLD) ovalue_r <= ovalue_nxt;
  end

endmodule
`default_nettype wire

/* sv/rse_checker.sv */
// Port-level checker for the row softmax engine, bound to the top level.
`default_nettype none
module rse_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [16:0] out_value,
  input wire logic        out_row_end
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_value) && $stable(out_row_end))
    else $error("stalled result changed");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("not idle after reset");

  a_end_frees: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_row_end |=> !out_valid)
    else $error("result after row end");

endmodule

bind row_softmax_engine rse_checker u_rse_checker (
  .clk, .rst_n, .in_stall, .out_valid, .out_stall, .out_value, .out_row_end
);
`default_nettype wire

/* tb/row_softmax_engine_test.sv */
// Testbench for the row softmax engine: directed table plus random rows against a predictor.
`timescale 1ns / 100ps
`default_nettype none
module row_softmax_engine_test;
  import rse_pkg::*;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic cfg_index;
  logic [LEN_W-1:0] cfg_data;
  logic in_valid;
  logic in_stall;
  logic signed [15:0] in_score;
  logic out_valid;
  logic out_stall;
  logic signed [16:0] out_value;
  logic out_row_end;

  row_softmax_engine dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_score(in_score),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_value(out_value), .out_row_end(out_row_end)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // predictor state
  logic       pm_mode;
  logic [6:0] pm_len;
  logic signed [15:0] pm_row [MAX_ROW];
  logic signed [15:0] pm_max;
  int unsigned pm_fill;

  typedef struct packed {
    logic [16:0] value;
    logic        row_end;
  } result_t;
  result_t pending_results[$];

  int errors;
  bit quiet_in;   // sender-side idling off
  bit quiet_out;  // receiver-side idling off
  int idle_cycles;

  // exp(-n/256) as unsigned Q1.16, built from the Taylor series and squaring chain
  function automatic longint unsigned exp_term(input int unsigned n);
    longint unsigned t, pos, neg, f, acc;
    if (n >= 4096) return 0;
    t = 64'd1 << 56;
    pos = t;
    neg = 0;
    for (int k = 1; k <= 8; k++) begin
      t = t / (64'd256 * longint'(k));
      if (k % 2 == 1) neg += t;
      else pos += t;
    end
    f = ((pos - neg) + (64'd1 << 23)) >> 24;
    acc = 64'd1 << 32;
    for (int i = 0; i < 12; i++) begin
      if (n[i]) acc = (acc * f + (64'd1 << 31)) >> 32;
      f = (f * f + (64'd1 << 31)) >> 32;
    end
    return (acc + (64'd1 << 15)) >> 16;
  endfunction

  // ln(total/65536) in Q8.8 via log2 by repeated squaring
  function automatic longint ln_q8(input int unsigned s);
    int unsigned k;
    logic [127:0] m, l2, prod;
    if (s < 65536) return 0;
    k = 0;
    while ((s >> (k + 1)) != 0 && k < 31) k++;
    m = 128'(s) << (31 - k);
    l2 = 128'(k - 16) << 16;
    for (int i = 0; i < 16; i++) begin
      m = (m * m) >> 31;
      if (m >= (128'd1 << 32)) begin
        l2 |= 128'd1 << (15 - i);
        m = m >> 1;
      end
    end
    prod = (l2 * 128'hB17217F8 + (128'd1 << 39)) >> 40;
    return longint'(prod[63:0]);
  endfunction

  // queue the results a score causes, if it closes a row
  task automatic predict_score(input logic signed [15:0] x);
    int unsigned len, total;
    longint lse, r, d;
    longint unsigned e, p;
    result_t res;
    len = pm_len;
    if (len < 1) len = 1;
    if (len > MAX_ROW) len = MAX_ROW;
    if (pm_fill >= MAX_ROW) pm_fill = 0;
    if (pm_fill == 0 || x > pm_max) pm_max = x;
    pm_row[pm_fill] = x;
    pm_fill++;
    if (pm_fill < len) return;
    total = 0;
    for (int j = 0; j < pm_fill; j++)
      total += int'(exp_term(int'(pm_max) - int'(pm_row[j])));
    total &= 32'h7FFFFF;
    lse = ln_q8(total);
    for (int j = 0; j < pm_fill; j++) begin
      d = longint'(pm_row[j]) - longint'(pm_max);
      if (pm_mode) begin
        r = d - lse;
        if (r < -32768) r = -32768;
        if (r > 32767) r = 32767;
        res.value = r[16:0];
      end else begin
        e = exp_term(int'(-d));
        p = 0;
        if (total != 0) p = (e * 65536 + total / 2) / total;
        if (p > 65535) p = 65535;
        res.value = p[16:0];
      end
      res.row_end = (j + 1 == pm_fill);
      pending_results = {pending_results, res};
    end
    pm_fill = 0;
  endtask

  // score transfer; idling off when quiet_in is set; valid stays up for the next one
  task automatic send_score(input logic signed [15:0] x);
    if (!quiet_in) begin
      while ($urandom_range(99) < 15) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_score <= x;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_score(x);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    // a row in progress emits nothing; allow the output register to settle
    repeat (60) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [6:0] val);
    in_valid <= 1'b0;
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_MODE) pm_mode = val[0];
    else pm_len = val;
    @(posedge clk);
  endtask

  // result checker and receiver-side stall
  always @(posedge clk) begin
    result_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        idle_cycles <= 0;
        if (pending_results.size() == 0) begin
          $error("unexpected result value=%0d", out_value);
          errors++;
        end else begin
          want = pending_results.pop_front();
          if (out_value !== want.value) begin
            $error("value: expected %0d got %0d", want.value, out_value);
            errors++;
          end
          if (out_row_end !== want.row_end) begin
            $error("row_end: expected %0d got %0d", want.row_end, out_row_end);
            errors++;
          end
        end
      end else if (in_valid && !in_stall) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      out_stall <= quiet_out ? 1'b0 : ($urandom_range(99) < 15);
    end
  end

  // watchdog: no transfer in either direction for too long
  always @(posedge clk) begin
    if (idle_cycles > 20000) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // directed rows: mode, row length, score, and the typed value of the row's
  // last result where it is plain (otherwise the predictor decides)
  typedef struct {
    logic       mode;
    logic [6:0] len;
    logic signed [15:0] x;
    logic       has_want;
    logic [16:0] want;
  } dir_row_t;
  localparam int DIR_N = 18;
  dir_row_t dir_rows [DIR_N] = '{
    '{1'b0, 7'd1, 16'sh7FFF,  1'b1, 17'd65535},
    '{1'b0, 7'd1, -16'sh8000, 1'b1, 17'd65535},
    '{1'b1, 7'd1, 16'sh0000,  1'b1, 17'd0},
    '{1'b1, 7'd0, 16'sh1234,  1'b1, 17'd0},
    '{1'b0, 7'd2, -16'sh8000, 1'b0, 17'd0},
    '{1'b0, 7'd2, 16'sh7FFF,  1'b1, 17'd65535},
    '{1'b1, 7'd2, -16'sh8000, 1'b0, 17'd0},
    '{1'b1, 7'd2, 16'sh7FFF,  1'b1, 17'd0},
    '{1'b0, 7'd3, 16'sh0100,  1'b0, 17'd0},
    '{1'b0, 7'd3, 16'sh0100,  1'b0, 17'd0},
    '{1'b0, 7'd3, 16'sh0100,  1'b0, 17'd0},
    '{1'b1, 7'd3, 16'sh0000,  1'b0, 17'd0},
    '{1'b1, 7'd3, -16'sh0F00, 1'b0, 17'd0},
    '{1'b1, 7'd3, -16'sh1000, 1'b0, 17'd0},
    '{1'b0, 7'd4, 16'sh5555,  1'b0, 17'd0},
    '{1'b0, 7'd4, -16'sh2AAB, 1'b0, 17'd0},
    '{1'b0, 7'd4, 16'sh5554,  1'b0, 17'd0},
    '{1'b0, 7'd4, 16'sh0001,  1'b0, 17'd0}
  };

  initial begin
    int sent;
    logic signed [15:0] x, base;
    int len;
    int last;
    errors = 0;
    idle_cycles = 0;
    quiet_in = 1'b0;
    quiet_out = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_MODE;
    cfg_data = '0;
    in_valid = 1'b0;
    in_score = '0;
    out_stall = 1'b0;
    pm_mode = 1'b0;
    pm_len = 7'd64;
    pm_max = '0;
    pm_fill = 0;
    for (int i = 0; i < MAX_ROW; i++) pm_row[i] = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: each row closes before the next register write
    for (int i = 0; i < DIR_N; i++) begin
      if (pm_fill == 0) begin
        write_reg(CFG_MODE, {6'd0, dir_rows[i].mode});
        write_reg(CFG_LEN, dir_rows[i].len);
      end
      send_score(dir_rows[i].x);
      if (dir_rows[i].has_want && pending_results.size() != 0) begin
        last = pending_results.size() - 1;
        pending_results[last].value = dir_rows[i].want;
      end
      if (pm_fill == 0) drain();
    end

    // one full-length row with the length set beyond the range
    write_reg(CFG_LEN, 7'd127);
    for (int i = 0; i < 64; i++) send_score(16'(i * 1031 - 32768));
    drain();

    // random rows, mostly short, some long; values near a base to keep terms alive
    sent = 0;
    while (sent < 260) begin
      write_reg(CFG_MODE, 7'($urandom_range(1)));
      len = ($urandom_range(9) == 0) ? $urandom_range(64) : $urandom_range(1, 8);
      write_reg(CFG_LEN, 7'(len));
      quiet_in = (sent > 90 && sent < 160);
      quiet_out = quiet_in;
      base = 16'($urandom);
      for (int i = 0; i < (len == 0 ? 1 : len); i++) begin
        if ($urandom_range(3) == 0) x = 16'($urandom);
        else x = base + 16'($signed(12'($urandom)));
        send_score(x);
        sent++;
      end
      if ($urandom_range(4) == 0) drain();
      else begin
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
      end
      repeat (60) @(posedge clk);
    end
    quiet_in = 1'b0;
    quiet_out = 1'b0;
    drain();

    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
